[sv/chrt_pkg.sv]
// ----------------------------------------------------------------------------
// chrt_pkg
// Shared types and codes for the consistent hash ring table.
// ----------------------------------------------------------------------------
package chrt_pkg;

	localparam int unsigned MAX_POINTS_DEF = 1024;
	localparam int unsigned MAX_NODES_DEF  = 256;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EMPTY   = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_ABSENT  = 3'd3;
	localparam logic [2:0] ST_PRESENT = 3'd4;

	typedef struct packed {
		logic [31:0] digest;
		logic [7:0]  owner;
	} entry_t;

endpackage

[sv/chrt_mem.sv]
// ----------------------------------------------------------------------------
// chrt_mem
// Point table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module chrt_mem
	import chrt_pkg::*;
#(
	parameter int unsigned DEPTH = MAX_POINTS_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic         clk,
	input  logic         we,
	input  logic [AW-1:0] waddr,
	input  entry_t       wdata,
	input  logic [AW-1:0] raddr,
	output entry_t       rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/consistent_hash_ring_table.sv]
// ----------------------------------------------------------------------------
// consistent_hash_ring_table
// Sorted table of ring points with insert, remove and successor lookup.
// ----------------------------------------------------------------------------
// Usage: drive mode, node_number, point_digest and first_point and raise
// start while busy is low; that edge accepts the transaction. busy stays
// high up to and including the cycle that shows the result. The result
// (found_node, status, point_total) is on its ports for exactly one cycle
// with done high; the receiver cannot stall it and must take it then.
// Timing is set by the single, registered read port of the point memory:
//   lookup: a binary search.
//   insert: a scan for an existing owner when first_point is set,
//           then a binary search, then a shift of the tail one entry at a time.
//   remove: an owner scan and a compaction pass.
// After reset the table is empty; the memory contents need no clearing
// because only entries below the point count are ever used.
// ----------------------------------------------------------------------------
module consistent_hash_ring_table
	import chrt_pkg::*;
#(
	parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
	parameter int unsigned MAX_NODES  = MAX_NODES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [7:0]  node_number,
	input  logic [31:0] point_digest,
	input  logic        first_point,
	output logic        done,
	output logic [7:0]  found_node,
	output logic [2:0]  status,
	output logic [10:0] point_total
);

	localparam int unsigned AW = $clog2(MAX_POINTS);
	localparam int unsigned CW = AW + 1;

	// Sequencer states. Each memory read takes a request state and a
	// result state, since read data is registered.
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_SCAN  = 10'b0000000010,
		S_SCANW = 10'b0000000100,
		S_BS    = 10'b0000001000,
		S_BSW   = 10'b0000010000,
		S_SHIFT = 10'b0000100000,
		S_SHW   = 10'b0001000000,
		S_COMP  = 10'b0010000000,
		S_COMPW = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t        state_q;
	logic [1:0]    mode_q;
	logic [7:0]    node_q;
	logic [31:0]   dig_q;
	logic          first_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] lo_q, hi_q, idx_q, wr_q;
	logic [2:0]    status_q;
	logic [7:0]    found_q;
	logic          done_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	entry_t        wdata, rdata;

	logic [CW-1:0] mid;
	logic          node_ok;

	assign mid     = lo_q + ((hi_q - lo_q) >> 1);
	assign node_ok = ({24'd0, node_q} < 32'(MAX_NODES));

	chrt_mem #(.DEPTH(MAX_POINTS), .AW(AW)) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Memory port control.
	always_comb begin
		we    = 1'b0;
		waddr = wr_q[AW-1:0];
		wdata = rdata;
		raddr = idx_q[AW-1:0];
		unique case (state_q)
			S_BS: begin
				// A search that ran past the last point wraps to the first one.
				raddr = (mid >= count_q) ? '0 : mid[AW-1:0];
			end
			S_SHW: begin
				// idx_q > lo_q: move entry idx-1 up to idx.
				we    = 1'b1;
				waddr = idx_q[AW-1:0];
				raddr = idx_q[AW-1:0] - AW'(1);
			end
			S_SHIFT: begin
				raddr = idx_q[AW-1:0] - AW'(1);
				if (idx_q == lo_q) begin
					we    = 1'b1;
					waddr = lo_q[AW-1:0];
					wdata = '{digest: dig_q, owner: node_q};
				end
			end
			S_COMPW: begin
				we    = (rdata.owner != node_q);
				waddr = wr_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			done_q   <= 1'b0;
			mode_q   <= '0;
			node_q   <= '0;
			dig_q    <= '0;
			first_q  <= 1'b0;
			lo_q     <= '0;
			hi_q     <= '0;
			idx_q    <= '0;
			wr_q     <= '0;
			status_q <= ST_OK;
			found_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start && !done_q) begin
						mode_q   <= mode;
						node_q   <= node_number;
						dig_q    <= point_digest;
						first_q  <= first_point;
						status_q <= ST_OK;
						found_q  <= '0;
						idx_q    <= '0;
						wr_q     <= '0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					// Decide the path; scan for ownership when needed.
					lo_q <= '0;
					hi_q <= count_q;
					if (mode_q == MODE_INSERT) begin
						if (!node_ok) begin
							status_q <= ST_ABSENT;
							state_q  <= S_DONE;
						end else if (first_q && idx_q < count_q) begin
							state_q <= S_SCANW;
						end else if (count_q == CW'(MAX_POINTS)) begin
							status_q <= ST_FULL;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_BS;
						end
					end else if (mode_q == MODE_REMOVE) begin
						if (!node_ok || idx_q == count_q) begin
							status_q <= ST_ABSENT;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_SCANW;
						end
					end else if (mode_q == MODE_LOOKUP) begin
						if (count_q == '0) begin
							status_q <= ST_EMPTY;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_BS;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SCANW: begin
					if (rdata.owner == node_q) begin
						if (mode_q == MODE_INSERT) begin
							status_q <= ST_PRESENT;
							state_q  <= S_DONE;
						end else begin
							idx_q   <= '0;
							state_q <= S_COMP;
						end
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_SCAN;
					end
				end
				S_BS: begin
					if (lo_q < hi_q) begin
						state_q <= S_BSW;
					end else if (mode_q == MODE_LOOKUP) begin
						idx_q   <= (lo_q >= count_q) ? '0 : lo_q;
						state_q <= S_BSW;
						hi_q    <= '0;
						lo_q    <= '1;
					end else begin
						idx_q   <= count_q;
						state_q <= S_SHIFT;
					end
				end
				S_BSW: begin
					if (lo_q == '1 && hi_q == '0) begin
						// Owner read of the chosen entry.
						found_q <= rdata.owner;
						state_q <= S_DONE;
					end else begin
						if (rdata.digest > dig_q) hi_q <= mid;
						else lo_q <= mid + CW'(1);
						state_q <= S_BS;
					end
				end
				S_SHIFT: begin
					if (idx_q == lo_q) begin
						count_q <= count_q + CW'(1);
						state_q <= S_DONE;
					end else begin
						state_q <= S_SHW;
					end
				end
				S_SHW: begin
					idx_q   <= idx_q - CW'(1);
					state_q <= S_SHIFT;
				end
				S_COMP: begin
					if (idx_q == count_q) begin
						count_q <= wr_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_COMPW;
					end
				end
				S_COMPW: begin
					if (rdata.owner != node_q) wr_q <= wr_q + CW'(1);
					idx_q   <= idx_q + CW'(1);
					state_q <= S_COMP;
				end
				S_DONE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE) || done_q;
	assign done        = done_q;
	assign found_node  = found_q;
	assign status      = status_q;
	assign point_total = 11'(count_q);

	// Concurrent checks on the sequencer.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS)) else $error("point count overflow");
	a_done_len: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("result shown twice");
	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != ST_OK) |-> found_q == '0)
		else $error("found_node set on failure");
	a_comp_wr: assert property (@(posedge clk) disable iff (!arst_n)
		wr_q <= idx_q || state_q == S_IDLE) else $error("compaction overran");

endmodule

[tb/chrt_ring_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chrt_ring_checker
// Predicts and checks every result of the consistent hash ring table.
// ----------------------------------------------------------------------------
module chrt_ring_checker
	import chrt_pkg::*;
#(
	parameter int unsigned RING_DEPTH = MAX_POINTS_DEF,
	parameter int unsigned NODE_LIMIT = MAX_NODES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  mode,
	input  logic [7:0]  node_number,
	input  logic [31:0] point_digest,
	input  logic        first_point,
	input  logic        done,
	input  logic [7:0]  found_node,
	input  logic [2:0]  status,
	input  logic [10:0] point_total,
	output int          fail_count,
	output int          outstanding
);

	typedef struct packed {
		logic [7:0]  node;
		logic [2:0]  code;
		logic [10:0] total;
	} ring_answer_t;

	logic [31:0]  ring_digest [RING_DEPTH];
	logic [7:0]   ring_owner  [RING_DEPTH];
	int unsigned  ring_count;
	ring_answer_t answer_queue [$];

	assign outstanding = answer_queue.size();

	function automatic bit node_on_ring(input logic [7:0] node);
		for (int unsigned i = 0; i < ring_count; i++)
			if (ring_owner[i] == node)
				return 1'b1;
		return 1'b0;
	endfunction

	// Index of the first point whose digest is strictly above the key.
	function automatic int unsigned successor_index(input logic [31:0] key);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		lo = 0;
		hi = ring_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (ring_digest[mid] > key)
				hi = mid;
			else
				lo = mid + 1;
		end
		return lo;
	endfunction

	function automatic ring_answer_t apply_ring_op(input logic [1:0] op, input logic [7:0] node,
			input logic [31:0] digest, input logic first);
		ring_answer_t ans;
		int unsigned pos;
		int unsigned wr;
		ans = '0;
		ans.code = ST_OK;
		if (op == MODE_INSERT) begin
			if (node >= NODE_LIMIT)
				ans.code = ST_ABSENT;
			else if (first && node_on_ring(node))
				ans.code = ST_PRESENT;
			else if (ring_count >= RING_DEPTH)
				ans.code = ST_FULL;
			else begin
				pos = successor_index(digest);
				for (int unsigned i = ring_count; i > pos; i--) begin
					ring_digest[i] = ring_digest[i - 1];
					ring_owner[i]  = ring_owner[i - 1];
				end
				ring_digest[pos] = digest;
				ring_owner[pos]  = node;
				ring_count++;
			end
		end else if (op == MODE_REMOVE) begin
			if (node >= NODE_LIMIT || !node_on_ring(node))
				ans.code = ST_ABSENT;
			else begin
				wr = 0;
				for (int unsigned i = 0; i < ring_count; i++)
					if (ring_owner[i] != node) begin
						ring_digest[wr] = ring_digest[i];
						ring_owner[wr]  = ring_owner[i];
						wr++;
					end
				ring_count = wr;
			end
		end else if (op == MODE_LOOKUP) begin
			if (ring_count == 0)
				ans.code = ST_EMPTY;
			else begin
				pos = successor_index(digest);
				if (pos >= ring_count)
					pos = 0;
				ans.node = ring_owner[pos];
			end
		end
		ans.total = ring_count[10:0];
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ring_answer_t want;
		if (!arst_n) begin
			ring_count = 0;
			fail_count = 0;
			answer_queue.delete();
		end else begin
			if (done) begin
				if (answer_queue.size() == 0) begin
					$error("result with no transaction outstanding");
					fail_count++;
				end else begin
					want = answer_queue.pop_front();
					if (found_node !== want.node) begin
						$error("found_node: expected %0d, got %0d", want.node, found_node);
						fail_count++;
					end
					if (status !== want.code) begin
						$error("status: expected %0d, got %0d", want.code, status);
						fail_count++;
					end
					if (point_total !== want.total) begin
						$error("point_total: expected %0d, got %0d", want.total, point_total);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				answer_queue.push_back(apply_ring_op(mode, node_number, point_digest,
					first_point));
		end
	end

endmodule

[tb/consistent_hash_ring_table_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// consistent_hash_ring_table_tb
// Stimulus and verdict for the consistent hash ring table.
// ----------------------------------------------------------------------------
// Directed transactions cover the empty ring, absent and present nodes, equal
// digests, wrap-around lookups and the unused mode. A fill pass then builds a
// table of over a hundred points with many equal digests, and a random phase
// mixes inserts, removes and lookups over a small node set and a pool of
// repeated digests. The checker beside the block predicts and compares every
// result.
// ----------------------------------------------------------------------------
module consistent_hash_ring_table_tb;
	import chrt_pkg::*;

	// The block ignores this mode; it still answers with an ok status.
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int unsigned FILL_ITEMS = 120;
	localparam int unsigned RANDOM_ITEMS = 400;
	localparam longint unsigned CYCLE_LIMIT = 40_000_000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  mode;
	logic [7:0]  node_number;
	logic [31:0] point_digest;
	logic        first_point;
	logic        done;
	logic [7:0]  found_node;
	logic [2:0]  status;
	logic [10:0] point_total;
	int          fail_count;
	int          outstanding;
	longint unsigned cycle_count;
	logic [31:0] digest_pool [16];

	consistent_hash_ring_table dut (
		.clk, .arst_n, .start, .busy, .mode, .node_number, .point_digest,
		.first_point, .done, .found_node, .status, .point_total
	);

	chrt_ring_checker checker_i (
		.clk, .arst_n, .start, .busy, .mode, .node_number, .point_digest,
		.first_point, .done, .found_node, .status, .point_total,
		.fail_count, .outstanding
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// A stuck handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Mostly back to back, sometimes a short pause, rarely a long one.
	task automatic idle_gap();
		int unsigned pick;
		int unsigned len;
		pick = $urandom_range(99);
		len = (pick < 65) ? 0 : (pick < 93) ? $urandom_range(3, 1) : $urandom_range(40, 8);
		if (len > 0) begin
			start <= 1'b0;
			repeat (len) @(posedge clk);
		end
	endtask

	// Called at a rising edge; returns at the edge that accepts the transaction.
	task automatic issue_ring_op(input logic [1:0] op, input logic [7:0] node,
			input logic [31:0] digest, input logic first);
		idle_gap();
		start        <= 1'b1;
		mode         <= op;
		node_number  <= node;
		point_digest <= digest;
		first_point  <= first;
		forever begin
			@(negedge clk);
			if (!busy)
				break;
			@(posedge clk);
		end
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_digest();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 45)
			return digest_pool[$urandom_range(15)];
		if (pick < 50)
			return (pick < 48) ? 32'h0 : 32'hFFFF_FFFF;
		return $urandom();
	endfunction

	initial begin
		int unsigned pick;
		logic [7:0] node;
		cycle_count  = 0;
		arst_n       = 1'b0;
		start        = 1'b0;
		mode         = MODE_LOOKUP;
		node_number  = '0;
		point_digest = '0;
		first_point  = 1'b0;
		for (int i = 0; i < 16; i++)
			digest_pool[i] = $urandom();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty ring, absent node, unused mode, equal digests, extremes.
		issue_ring_op(MODE_LOOKUP, 8'd0, 32'h0, 1'b0);
		issue_ring_op(MODE_REMOVE, 8'd7, 32'h0, 1'b0);
		issue_ring_op(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF, 1'b1);
		issue_ring_op(MODE_INSERT, 8'd0, 32'h0, 1'b1);
		issue_ring_op(MODE_INSERT, 8'hFF, 32'hFFFF_FFFF, 1'b1);
		issue_ring_op(MODE_INSERT, 8'd0, 32'h8000_0000, 1'b1);
		issue_ring_op(MODE_INSERT, 8'd9, 32'h8000_0000, 1'b0);
		issue_ring_op(MODE_INSERT, 8'd5, 32'h8000_0000, 1'b1);
		issue_ring_op(MODE_LOOKUP, 8'd0, 32'h0, 1'b0);
		issue_ring_op(MODE_LOOKUP, 8'd0, 32'h7FFF_FFFF, 1'b0);
		issue_ring_op(MODE_LOOKUP, 8'd0, 32'h8000_0000, 1'b0);
		issue_ring_op(MODE_LOOKUP, 8'd0, 32'hFFFF_FFFF, 1'b0);
		issue_ring_op(MODE_LOOKUP, 8'd0, 32'hFFFF_FFFE, 1'b0);
		issue_ring_op(MODE_REMOVE, 8'd9, 32'h0, 1'b0);
		issue_ring_op(MODE_REMOVE, 8'hFF, 32'h0, 1'b0);
		issue_ring_op(MODE_LOOKUP, 8'd0, 32'hFFFF_FFFF, 1'b0);
		issue_ring_op(MODE_REMOVE, 8'd0, 32'h0, 1'b0);
		issue_ring_op(MODE_REMOVE, 8'd5, 32'h0, 1'b0);
		issue_ring_op(MODE_LOOKUP, 8'd0, 32'h1234_5678, 1'b0);

		// Build a larger table with later replicas of a few nodes.
		for (int i = 0; i < FILL_ITEMS; i++)
			issue_ring_op(MODE_INSERT, 8'($urandom_range(31)), pick_digest(), 1'b0);
		issue_ring_op(MODE_INSERT, 8'd3, 32'h0, 1'b1);
		issue_ring_op(MODE_INSERT, 8'd200, 32'h0, 1'b1);
		for (int i = 0; i < 8; i++)
			issue_ring_op(MODE_LOOKUP, 8'd0, pick_digest(), 1'b0);
		for (int i = 0; i < 30; i++)
			issue_ring_op(MODE_REMOVE, 8'(i), 32'h0, 1'b0);

		// Random phase over a small node set so that removes usually hit.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(99);
			node = ($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(15));
			if (pick < 42)
				issue_ring_op(MODE_INSERT, node, pick_digest(), 1'($urandom()));
			else if (pick < 52)
				issue_ring_op(MODE_REMOVE, node, $urandom(), 1'($urandom()));
			else if (pick < 95)
				issue_ring_op(MODE_LOOKUP, 8'($urandom()), pick_digest(), 1'($urandom()));
			else
				issue_ring_op(MODE_UNUSED, 8'($urandom()), $urandom(), 1'($urandom()));
		end
		start <= 1'b0;

		forever begin
			@(negedge clk);
			if (outstanding == 0)
				break;
		end
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[consistent_hash_ring_table.f]
sv/chrt_pkg.sv
sv/chrt_mem.sv
sv/consistent_hash_ring_table.sv
tb/chrt_ring_checker.sv
tb/consistent_hash_ring_table_tb.sv
